// ===== hdl/crc32c_block_frame_verifier_core_assert.svh =====
// ----------------------------------------------------------------------------
// CRC32C block frame verifier assertion macros
// Immediate-style wrappers for concurrent checks; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CRC32C_BLOCK_FRAME_VERIFIER_CORE_ASSERT_SVH
`define CRC32C_BLOCK_FRAME_VERIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CBFV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbfv assertion failed");

// next-cycle implication
`define CBFV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbfv assertion failed");

`else

`define CBFV_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CBFV_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/cbfv_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfv_pkg
// Types, codes and the CRC32C byte update for the block frame verifier.
// ----------------------------------------------------------------------------
package cbfv_pkg;

  localparam int TOTAL_W   = 48;
  localparam int CONSUME_W = TOTAL_W + 1;
  localparam int WORD_W    = 32;
  localparam int REG_IDX_W = 1;

  // length word plus stored CRC word
  localparam logic [CONSUME_W-1:0] HEADER_BYTES = CONSUME_W'(8);

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TOTAL_REGION_BYTES = 1'b0,
    REG_BLOCK_COUNT        = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_HEADER   = 2'd1,
    PH_CONTENTS = 2'd2,
    PH_DONE     = 2'd3
  } phase_t;

  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0]  block_index;
    logic [1:0]         status;
    logic [WORD_W-1:0]  stored_crc;
    logic [WORD_W-1:0]  computed_crc;
    logic [TOTAL_W-1:0] block_offset;
    logic               last;
  } verdict_t;

  // reflected CRC32C, one byte, bitwise
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc32c_block_frame_verifier_core.sv =====
// ----------------------------------------------------------------------------
// crc32c_block_frame_verifier_core
// Walks a region of length/CRC framed blocks and reports one verdict per block.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid / byte_stall, data_byte, region_start) carries the
//   region one byte per word; region_start marks the first byte and restarts
//   checking at any time. Each block is a 4-byte LE length, a 4-byte LE stored
//   CRC32C, then the contents. Verdict channel (verdict_valid / verdict_stall)
//   carries block_index, status, stored_crc, computed_crc, block_offset, last.
//   Configuration (wr_en, wr_index, wr_data) sets the region size and block
//   count; write only while no byte is in flight.
// Timing:
//   One byte per cycle sustained while byte_stall is low. An accepted byte is
//   processed straight out of the input register once no verdict waits in
//   the skid; its verdict (if any) is registered into the output register or,
//   while that one is held, into the skid register. The path per byte is one
//   CRC32C byte update, or one 49-bit add and compare.
// Reset: clears phase (idle, ignoring bytes until region_start), both config
//   registers and both output slots.
// Stall: a verdict held by verdict_stall still lets one more verdict land in
//   a skid register; only when the skid is full does byte_stall rise.
// ----------------------------------------------------------------------------
`include "crc32c_block_frame_verifier_core_assert.svh"

module crc32c_block_frame_verifier_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          wr_en,
  input  logic [cbfv_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [cbfv_pkg::TOTAL_W-1:0]  wr_data,
  // byte channel
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          region_start,
  // verdict channel
  output logic                          verdict_valid,
  input  logic                          verdict_stall,
  output logic [31:0]                   block_index,
  output logic [1:0]                    status,
  output logic [31:0]                   stored_crc,
  output logic [31:0]                   computed_crc,
  output logic [cbfv_pkg::TOTAL_W-1:0]  block_offset,
  output logic                          last
);

  // configuration registers
  logic [cbfv_pkg::TOTAL_W-1:0] total_region_bytes;
  logic [31:0]                  block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_region_bytes <= '0;
      block_count        <= '0;
    end else if (wr_en) begin
      unique case (cbfv_pkg::reg_idx_t'(wr_index))
        cbfv_pkg::REG_TOTAL_REGION_BYTES: total_region_bytes <= wr_data;
        cbfv_pkg::REG_BLOCK_COUNT:        block_count        <= wr_data[31:0];
      endcase
    end
  end

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_start;
  logic       skid_valid;
  logic       proc_en;

  assign byte_stall = stage_valid & skid_valid;
  assign proc_en    = stage_valid & ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!byte_stall) begin
      stage_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      stage_byte  <= data_byte;
      stage_start <= region_start;
    end
  end

  // frame state
  cbfv_pkg::phase_t                phase, phase_next;
  logic [2:0]                      header_byte_count, header_byte_count_next;
  logic [31:0]                     length_word, length_word_next;
  logic [31:0]                     stored_crc_word, stored_crc_word_next;
  logic [31:0]                     running_crc, running_crc_next;
  logic [31:0]                     contents_remaining, contents_remaining_next;
  logic [cbfv_pkg::CONSUME_W-1:0]  consumed_bytes, consumed_bytes_next;
  logic [cbfv_pkg::TOTAL_W-1:0]    current_offset, current_offset_next;
  logic [31:0]                     current_block, current_block_next;

  logic                 res_emit;
  cbfv_pkg::verdict_t   res;

  always_comb begin
    logic [3:0]  n_inc;
    logic [31:0] calc;
    logic        do_verdict;

    phase_next              = phase;
    header_byte_count_next  = header_byte_count;
    length_word_next        = length_word;
    stored_crc_word_next    = stored_crc_word;
    running_crc_next        = running_crc;
    contents_remaining_next = contents_remaining;
    consumed_bytes_next     = consumed_bytes;
    current_offset_next     = current_offset;
    current_block_next      = current_block;
    res_emit                = 1'b0;
    res                     = '0;
    n_inc                   = 4'd0;
    calc                    = 32'd0;
    do_verdict              = 1'b0;

    if (proc_en) begin
      // region start: fresh region, byte counts as its first unless block count is 0
      if (stage_start) begin
        header_byte_count_next  = 3'd0;
        length_word_next        = 32'd0;
        stored_crc_word_next    = 32'd0;
        running_crc_next        = 32'hFFFF_FFFF;
        contents_remaining_next = 32'd0;
        consumed_bytes_next     = '0;
        current_offset_next     = '0;
        current_block_next      = 32'd0;
        phase_next = (block_count == 32'd0) ? cbfv_pkg::PH_DONE : cbfv_pkg::PH_HEADER;
      end

      if (!(stage_start && block_count == 32'd0)) begin
        case (phase_next)
          cbfv_pkg::PH_HEADER: begin
            if (!header_byte_count_next[2]) begin
              length_word_next = length_word_next |
                ({24'd0, stage_byte} << {header_byte_count_next[1:0], 3'b000});
            end else begin
              stored_crc_word_next = stored_crc_word_next |
                ({24'd0, stage_byte} << {header_byte_count_next[1:0], 3'b000});
            end
            n_inc = {1'b0, header_byte_count_next} + 4'd1;
            header_byte_count_next = n_inc[2:0];
            if (n_inc == 4'd4) begin
              consumed_bytes_next = consumed_bytes_next + cbfv_pkg::HEADER_BYTES +
                                    cbfv_pkg::CONSUME_W'(length_word_next);
              if (consumed_bytes_next > {1'b0, total_region_bytes}) begin
                res_emit         = 1'b1;
                res.block_index  = current_block_next;
                res.status       = cbfv_pkg::ST_OVERRUN;
                res.stored_crc   = 32'd0;
                res.computed_crc = 32'd0;
                res.block_offset = current_offset_next;
                res.last         = 1'b1;
                phase_next       = cbfv_pkg::PH_DONE;
              end
            end else if (n_inc == 4'd8) begin
              header_byte_count_next = 3'd0;
              if (length_word_next == 32'd0) begin
                do_verdict = 1'b1;
              end else begin
                contents_remaining_next = length_word_next;
                phase_next              = cbfv_pkg::PH_CONTENTS;
              end
            end
          end
          cbfv_pkg::PH_CONTENTS: begin
            running_crc_next        = cbfv_pkg::crc32c_byte(running_crc_next, stage_byte);
            contents_remaining_next = contents_remaining_next - 32'd1;
            do_verdict              = (contents_remaining_next == 32'd0);
          end
          default: ;  // idle or done: byte ignored
        endcase
      end

      if (do_verdict) begin
        calc             = ~running_crc_next;
        res_emit         = 1'b1;
        res.block_index  = current_block_next;
        res.stored_crc   = stored_crc_word_next;
        res.computed_crc = calc;
        res.block_offset = current_offset_next;
        if (calc != stored_crc_word_next) begin
          res.status = cbfv_pkg::ST_MISMATCH;
          res.last   = 1'b1;
          phase_next = cbfv_pkg::PH_DONE;
        end else if (({1'b0, current_block_next} + 33'd1) >= {1'b0, block_count}) begin
          res.status = cbfv_pkg::ST_MATCH;
          res.last   = 1'b1;
          phase_next = cbfv_pkg::PH_DONE;
        end else begin
          res.status              = cbfv_pkg::ST_MATCH;
          res.last                = 1'b0;
          current_block_next      = current_block_next + 32'd1;
          current_offset_next     = consumed_bytes_next[cbfv_pkg::TOTAL_W-1:0];
          header_byte_count_next  = 3'd0;
          length_word_next        = 32'd0;
          stored_crc_word_next    = 32'd0;
          running_crc_next        = 32'hFFFF_FFFF;
          contents_remaining_next = 32'd0;
          phase_next              = cbfv_pkg::PH_HEADER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= cbfv_pkg::PH_IDLE;
      header_byte_count  <= 3'd0;
      length_word        <= 32'd0;
      stored_crc_word    <= 32'd0;
      running_crc        <= 32'hFFFF_FFFF;
      contents_remaining <= 32'd0;
      consumed_bytes     <= '0;
      current_offset     <= '0;
      current_block      <= 32'd0;
    end else begin
      phase              <= phase_next;
      header_byte_count  <= header_byte_count_next;
      length_word        <= length_word_next;
      stored_crc_word    <= stored_crc_word_next;
      running_crc        <= running_crc_next;
      contents_remaining <= contents_remaining_next;
      consumed_bytes     <= consumed_bytes_next;
      current_offset     <= current_offset_next;
      current_block      <= current_block_next;
    end
  end

  // result register plus skid
  logic               out_valid;
  cbfv_pkg::verdict_t out_word;
  cbfv_pkg::verdict_t skid_word;
  logic               take;

  assign take = out_valid & ~verdict_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_emit) begin
      if (out_valid && verdict_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_word <= skid_word;
      end
    end else if (res_emit) begin
      if (out_valid && verdict_stall) begin
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end
  end

  assign verdict_valid = out_valid;
  assign block_index   = out_word.block_index;
  assign status        = out_word.status;
  assign stored_crc    = out_word.stored_crc;
  assign computed_crc  = out_word.computed_crc;
  assign block_offset  = out_word.block_offset;
  assign last          = out_word.last;

  // checks
  `CBFV_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `CBFV_ASSERT_NOW(a_contents_nonzero, clk, rst, phase == cbfv_pkg::PH_CONTENTS,
                   contents_remaining != 32'd0)
  `CBFV_ASSERT_NOW(a_offset_le_consumed, clk, rst, 1'b1,
                   {1'b0, current_offset} <= consumed_bytes)
  `CBFV_ASSERT_NEXT(a_overrun_stops, clk, rst,
                    res_emit && res.status == cbfv_pkg::ST_OVERRUN,
                    phase == cbfv_pkg::PH_DONE)

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// CRC32C block frame verifier testbench
// Drives framed byte regions through the verifier core and checks every
// verdict, field by field, against a cycle-free predictor of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
  localparam logic [47:0] ALL48           = 48'hFFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 1500;     // bytes sent in the random part
  localparam int SETTLE       = 6;        // input reg + process + output slot, rounded up
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int CYCLE_LIMIT  = 400000;

  // --------------------------------------------------------------------------
  // DUT signals; everything the bench drives is known from time zero
  // --------------------------------------------------------------------------
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           wr_en = 1'b0;
  logic [cbfv_pkg::REG_IDX_W-1:0] wr_index = '0;
  logic [cbfv_pkg::TOTAL_W-1:0]   wr_data = '0;
  logic                           byte_valid = 1'b0;
  logic                           byte_stall;
  logic [7:0]                     data_byte = '0;
  logic                           region_start = 1'b0;
  logic                           verdict_valid;
  logic                           verdict_stall = 1'b0;
  logic [31:0]                    block_index;
  logic [1:0]                     status;
  logic [31:0]                    stored_crc;
  logic [31:0]                    computed_crc;
  logic [cbfv_pkg::TOTAL_W-1:0]   block_offset;
  logic                           last;

  crc32c_block_frame_verifier_core dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .data_byte(data_byte), .region_start(region_start),
    .verdict_valid(verdict_valid), .verdict_stall(verdict_stall),
    .block_index(block_index), .status(status), .stored_crc(stored_crc),
    .computed_crc(computed_crc), .block_offset(block_offset), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the walker and of both registers
  // --------------------------------------------------------------------------
  logic [47:0]      cfg_total;
  logic [31:0]      cfg_blocks;
  cbfv_pkg::phase_t walk_phase;
  logic [2:0]       hdr_count;
  logic [31:0]      len_word;
  logic [31:0]      crc_word;
  logic [31:0]      crc_acc;
  logic [31:0]      bytes_left;
  logic [48:0]      region_used;   // header + contents of every block seen so far
  logic [47:0]      block_base;
  logic [31:0]      block_no;

  cbfv_pkg::verdict_t verdicts_due[$];  // verdicts the block owes, oldest first
  cbfv_pkg::verdict_t head_verdict;
  int       errors = 0;
  int       busy_bytes = 0;   // bytes accepted in the random part
  int       cycle_count;

  // idling / pressure controls
  bit       no_idle = 1'b0;
  int       hold_seq = 0;     // bumped by the stimulus to request a long hold
  int       hold_seen = 0;
  int       hold_left = 0;
  int       stall_left = 0;

  // directed table row: either a register write or one byte word
  typedef struct {
    bit                             is_cfg;
    logic [cbfv_pkg::REG_IDX_W-1:0] idx;
    logic [47:0]                    value;
    logic [7:0]                     b;
    logic                           rs;
    bit                             fixed;       // expected verdict typed in below
    cbfv_pkg::verdict_t             want;
  } row_t;
  row_t directed[$];

  // reflected CRC32C, one byte, bit-serial with the data bit folded into feedback
  function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) r = r ^ CASTAGNOLI_POLY;
    end
    return r;
  endfunction

  function automatic cbfv_pkg::verdict_t pack_verdict(input logic [31:0] idx,
                                                      input logic [1:0] st,
                                                      input logic [31:0] scrc,
                                                      input logic [31:0] ccrc,
                                                      input logic [47:0] offs,
                                                      input logic lst);
    cbfv_pkg::verdict_t v;
    v.block_index  = idx;
    v.status       = st;
    v.stored_crc   = scrc;
    v.computed_crc = ccrc;
    v.block_offset = offs;
    v.last         = lst;
    return v;
  endfunction

  function automatic void clear_block();
    hdr_count  = '0;
    len_word   = '0;
    crc_word   = '0;
    crc_acc    = '1;
    bytes_left = '0;
  endfunction

  function automatic void reset_model();
    cfg_total   = '0;
    cfg_blocks  = '0;
    walk_phase  = cbfv_pkg::PH_IDLE;
    clear_block();
    region_used = '0;
    block_base  = '0;
    block_no    = '0;
  endfunction

  // end of a block's contents: compare CRCs, maybe move on to the next header
  task automatic close_block(output bit produced, output cbfv_pkg::verdict_t v);
    logic [31:0] calc;
    calc     = ~crc_acc;
    produced = 1'b1;
    if (calc != crc_word) begin
      v = pack_verdict(block_no, cbfv_pkg::ST_MISMATCH, crc_word, calc, block_base, 1'b1);
      walk_phase = cbfv_pkg::PH_DONE;
    end else if (33'(block_no) + 33'd1 >= 33'(cfg_blocks)) begin
      // also catches a count lowered below the current block
      v = pack_verdict(block_no, cbfv_pkg::ST_MATCH, crc_word, calc, block_base, 1'b1);
      walk_phase = cbfv_pkg::PH_DONE;
    end else begin
      v = pack_verdict(block_no, cbfv_pkg::ST_MATCH, crc_word, calc, block_base, 1'b0);
      block_no   = block_no + 32'd1;
      block_base = region_used[47:0];
      clear_block();
      walk_phase = cbfv_pkg::PH_HEADER;
    end
  endtask

  // one accepted byte word -> zero or one verdict
  task automatic predict_verdict(input logic [7:0] b, input logic rs,
                                 output bit produced, output cbfv_pkg::verdict_t v);
    logic [2:0] n;
    produced = 1'b0;
    v        = '0;
    if (rs) begin
      // restart wins over anything in progress
      clear_block();
      region_used = '0;
      block_base  = '0;
      block_no    = '0;
      if (cfg_blocks == 32'd0) begin
        walk_phase = cbfv_pkg::PH_DONE;
        return;
      end
      walk_phase = cbfv_pkg::PH_HEADER;
    end
    case (walk_phase)
      cbfv_pkg::PH_HEADER: begin
        n = hdr_count;
        if (n < 3'd4) len_word = len_word | (32'(b) << (8 * n));
        else          crc_word = crc_word | (32'(b) << (8 * (n - 3'd4)));
        hdr_count = n + 3'd1;
        if (n == 3'd3) begin
          // length known: overrun verdict comes before the stored CRC is read
          region_used = region_used + 49'd8 + 49'(len_word);
          if (region_used > 49'(cfg_total)) begin
            v = pack_verdict(block_no, cbfv_pkg::ST_OVERRUN, 32'd0, 32'd0, block_base, 1'b1);
            produced   = 1'b1;
            walk_phase = cbfv_pkg::PH_DONE;
          end
        end else if (n == 3'd7) begin
          hdr_count = '0;
          if (len_word == 32'd0) begin
            close_block(produced, v);
          end else begin
            bytes_left = len_word;
            walk_phase = cbfv_pkg::PH_CONTENTS;
          end
        end
      end
      cbfv_pkg::PH_CONTENTS: begin
        crc_acc    = crc32c_step(crc_acc, b);
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) close_block(produced, v);
      end
      default: ;  // idle or done: byte dropped
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR t=%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic bit stray_restart();
    return $urandom_range(0, 199) == 0;
  endfunction

  // Receiver: checks each accepted verdict word, then draws its stall.
  // The long hold is counted here too, so stall has a single driver.
  always @(posedge clk) begin
    if (rst) begin
      verdict_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (verdict_valid && !verdict_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("verdict with nothing pending, block_index",
                          64'(block_index), 64'd0);
        end else begin
          head_verdict = verdicts_due.pop_front();
          check_field("block_index",  64'(block_index),  64'(head_verdict.block_index));
          check_field("status",       64'(status),       64'(head_verdict.status));
          check_field("stored_crc",   64'(stored_crc),   64'(head_verdict.stored_crc));
          check_field("computed_crc", 64'(computed_crc), 64'(head_verdict.computed_crc));
          check_field("block_offset", 64'(block_offset), 64'(head_verdict.block_offset));
          check_field("last",         64'(last),         64'(head_verdict.last));
        end
        stall_left = draw_wait();
      end else if (verdict_valid && stall_left > 0) begin
        stall_left--;
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      verdict_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one byte word after a random gap; predict on acceptance.
  // Valid is left high so a zero gap runs words back to back.
  task automatic send_byte(input logic [7:0] b, input logic rs, input bit fixed,
                           input cbfv_pkg::verdict_t want);
    int                 gap;
    bit                 produced;
    cbfv_pkg::verdict_t v;
    gap = draw_wait();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid   <= 1'b1;
    data_byte    <= b;
    region_start <= rs;
    do @(posedge clk); while (byte_stall);
    busy_bytes++;
    predict_verdict(b, rs, produced, v);
    if (fixed)         verdicts_due.push_back(want);
    else if (produced) verdicts_due.push_back(v);
  endtask

  // Drop valid and wait for the block to pay every verdict; with settle,
  // also wait out bytes still in flight that owe nothing.
  task automatic wait_results(input bit settle);
    byte_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  // idle-only register write; the extra wait after dropping wr_en keeps it to one NBA per step
  task automatic write_reg(input cbfv_pkg::reg_idx_t idx, input logic [47:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      cbfv_pkg::REG_TOTAL_REGION_BYTES: cfg_total  = val;
      cbfv_pkg::REG_BLOCK_COUNT:        cfg_blocks = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
  endfunction

  function automatic void add_cfg(input cbfv_pkg::reg_idx_t idx, input logic [47:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = val;
    directed.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic rs);
    row_t r;
    r = '{default: '0};
    r.b  = b;
    r.rs = rs;
    directed.push_back(r);
  endfunction

  function automatic void add_checked(input logic [7:0] b, input logic rs,
                                      input cbfv_pkg::verdict_t v);
    row_t r;
    r = '{default: '0};
    r.b     = b;
    r.rs    = rs;
    r.fixed = 1'b1;
    r.want  = v;
    directed.push_back(r);
  endfunction

  // One random region: new settings, then mostly well-formed blocks with
  // random contents; some bad CRCs, overruns, restarts and truncations.
  task automatic run_random_phase(input int pno);
    logic [31:0] lens[$];
    logic [7:0]  body[$];
    logic [31:0] len;
    logic [31:0] crc;
    logic [48:0] prefix;
    logic [47:0] total;
    logic [47:0] count_word;
    logic [7:0]  b;
    int          nblk, sel, j, cut, i, k;
    bit          stress;

    stress = (pno == 2) || (pno == 9);
    nblk   = stress ? 8 : $urandom_range(1, 6);
    for (k = 0; k < nblk; k++) begin
      sel = $urandom_range(0, 99);
      if (stress)        len = $urandom_range(0, 3);
      else if (sel < 60) len = $urandom_range(0, 16);
      else if (sel < 90) len = $urandom_range(17, 64);
      else if (sel < 97) len = $urandom_range(200, 400);
      else               len = $urandom();   // never finished inside this phase
      lens.push_back(len);
    end

    // region size: extremes, random, or placed around block j's end
    j      = $urandom_range(0, nblk - 1);
    prefix = '0;
    for (k = 0; k < j; k++) prefix = prefix + 49'd8 + 49'(lens[k]);
    sel = $urandom_range(0, 9);
    if (stress || sel < 4) total = ALL48;
    else if (sel == 4)     total = '0;
    else if (sel == 5)     total = rand48();
    else if (sel == 6)     total = 48'(prefix + 49'd7 + 49'(lens[j]));  // one byte short
    else if (sel == 7)     total = 48'(prefix + 49'd8 + 49'(lens[j]));  // exact fit
    else                   total = 48'(prefix + 49'($urandom_range(0, 7)));

    sel = $urandom_range(0, 9);
    if (stress || sel == 1) count_word = ALL48;
    else if (sel == 0)      count_word = '0;
    else if (sel == 2)      count_word = rand48();
    else                    count_word = 48'($urandom_range(1, nblk + 1));

    wait_results(1'b1);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(cbfv_pkg::REG_TOTAL_REGION_BYTES, total);
      write_reg(cbfv_pkg::REG_BLOCK_COUNT, count_word);
    end else begin
      write_reg(cbfv_pkg::REG_BLOCK_COUNT, count_word);
      write_reg(cbfv_pkg::REG_TOTAL_REGION_BYTES, total);
    end

    no_idle = stress || ($urandom_range(0, 4) == 0);
    // hold the verdict side long enough that the skid fills and bytes back up
    if (stress) hold_seq <= hold_seq + 1;

    for (k = 0; k < nblk; k++) begin
      len = lens[k];
      body.delete();
      crc = '1;
      cut = (len > 32'd400) ? $urandom_range(0, 40) : int'(len);
      for (i = 0; i < cut; i++) begin
        b = 8'($urandom());
        body.push_back(b);
        crc = crc32c_step(crc, b);
      end
      crc = ~crc;
      if (!stress && $urandom_range(0, 7) == 0) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      for (i = 0; i < 4; i++) send_byte(len[8*i +: 8], (k == 0 && i == 0) || stray_restart(),
                                        1'b0, '0);
      for (i = 0; i < 4; i++) send_byte(crc[8*i +: 8], stray_restart(), 1'b0, '0);
      foreach (body[i]) send_byte(body[i], stray_restart(), 1'b0, '0);
      if (cut != int'(len)) break;
      // sender pause in mid-region until everything owed has come out
      if ((pno == 4 && k == nblk / 2) || $urandom_range(0, 24) == 0) wait_results(1'b0);
    end
    // trailing junk: dropped if the region is done, eaten otherwise
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom()), 1'b0, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_no;
    reset_model();

    // registers at their reset values: idle drop, then zero-count start
    add_cfg(cbfv_pkg::REG_TOTAL_REGION_BYTES, 48'd0);
    add_cfg(cbfv_pkg::REG_BLOCK_COUNT, 48'd0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'hFF, 1'b1);
    // one block, empty region: restart mid-header, then overrun on length
    add_cfg(cbfv_pkg::REG_BLOCK_COUNT, 48'd1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_checked(8'h00, 1'b0,
                pack_verdict(32'd0, cbfv_pkg::ST_OVERRUN, 32'd0, 32'd0, 48'd0, 1'b1));
    // largest settings: empty block matches, then a one-byte block with bad CRC
    add_cfg(cbfv_pkg::REG_TOTAL_REGION_BYTES, ALL48);
    add_cfg(cbfv_pkg::REG_BLOCK_COUNT, ALL48);
    add_byte(8'h00, 1'b1);
    repeat (6) add_byte(8'h00, 1'b0);
    add_checked(8'h00, 1'b0,
                pack_verdict(32'd0, cbfv_pkg::ST_MATCH, 32'd0, 32'd0, 48'd0, 1'b0));
    add_byte(8'h01, 1'b0);
    repeat (3) add_byte(8'h00, 1'b0);
    repeat (5) add_byte(8'hFF, 1'b0);
    add_byte(8'h5A, 1'b0);   // after the mismatch: region done, dropped

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_results(1'b1);
        write_reg(cbfv_pkg::reg_idx_t'(directed[i].idx), directed[i].value);
      end else begin
        send_byte(directed[i].b, directed[i].rs, directed[i].fixed, directed[i].want);
      end
    end

    busy_bytes = 0;
    phase_no   = 0;
    while (busy_bytes < RANDOM_ITEMS) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    wait_results(1'b1);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog: a hang or a verdict that never comes ends here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: cycle limit reached, %0d verdicts still pending", verdicts_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cbfv_pkg.sv
hdl/crc32c_block_frame_verifier_core.sv
sim/testbench.sv
